### rtl/core/cvsd_pkg.sv
`timescale 1ns / 1ps

package cvsd_pkg;

	localparam int NCOL = 6;
	localparam logic [11:0] MAX_RECORDS = 12'hFFF;

	// result kinds
	localparam logic [2:0] STAT_HDR_OK  = 3'd0;
	localparam logic [2:0] STAT_HDR_ERR = 3'd1;
	localparam logic [2:0] STAT_SPAN    = 3'd2;
	localparam logic [2:0] STAT_END_OK  = 3'd3;
	localparam logic [2:0] STAT_END_ERR = 3'd4;

	// last varint group index (tenth byte)
	localparam logic [3:0] VI_LAST_IDX = 4'd9;

	typedef struct packed {
		logic       func;
		logic [7:0] payload_byte;
		logic       byte_last;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] cell_index;
		logic [31:0] region_id;
		logic [15:0] clearance;
		logic [7:0]  span_flags;
		logic [7:0]  step_bits;
		logic [31:0] height_quant;
		logic        is_fill;
		logic [31:0] min_height_bits;
		logic [31:0] region_count;
		logic [11:0] record_count;
		logic        last;
	} out_t;

	typedef struct packed {
		logic feed;
		logic first;
	} vi_ctl_t;

	typedef struct packed {
		logic [31:0] val;
		logic        hi;
		logic        bad;
	} vi_res_t;

endpackage

### rtl/core/cvsd_varint.sv
`timescale 1ns / 1ps

module cvsd_varint (
	input  logic              clk,
	input  logic              arst_n,
	input  cvsd_pkg::vi_ctl_t ctl,
	input  logic [7:0]        din,
	output cvsd_pkg::vi_res_t res
);
	import cvsd_pkg::*;

	logic [31:0] acc_q;
	logic        hi_q;
	logic [3:0]  cnt_q;
	logic [3:0]  idx;
	logic [6:0]  grp;
	logic [31:0] lo_add;
	logic        hi_add;

	assign idx = ctl.first ? 4'd0 : cnt_q;
	assign grp = din[6:0];

	// place the 7-bit group; bits at 32 and above only mark overflow
	always_comb begin
		lo_add = '0;
		hi_add = 1'b0;
		case (idx)
			4'd0: lo_add = {25'd0, grp};
			4'd1: lo_add = {18'd0, grp, 7'd0};
			4'd2: lo_add = {11'd0, grp, 14'd0};
			4'd3: lo_add = {4'd0, grp, 21'd0};
			4'd4: begin
				lo_add = {grp[3:0], 28'd0};
				hi_add = grp[6:4] != 3'd0;
			end
			4'd5, 4'd6, 4'd7, 4'd8: hi_add = grp != 7'd0;
			4'd9: hi_add = grp[0];
			default: hi_add = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			hi_q  <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.feed) begin
			acc_q <= (ctl.first ? 32'd0 : acc_q) | lo_add;
			hi_q  <= (ctl.first ? 1'b0 : hi_q) | hi_add;
			cnt_q <= idx + 4'd1;
		end
	end

	assign res.val = acc_q;
	assign res.hi  = hi_q;
	assign res.bad = ctl.feed && din[7] && (idx == VI_LAST_IDX);

endmodule

### rtl/core/columnar_varint_span_decoder_core.sv
`timescale 1ns / 1ps

// columnar span decoder: func 0 items load payload bytes into an on-chip byte
// buffer, one item per cycle; the item marked byte_last triggers header parsing
// and yields the header result (ok or error). func 1 items then each yield one
// span record or the closing end result (last = 1). all varint parsing runs
// through one shared LEB128 accumulator fed from the single buffer read port,
// and raw bytes use the same port: each buffered byte passes an address state
// and a registered read-data state, and each field ends in a dispatch state.
// a span pull also reads a cell descriptor when it crosses into a new cell.
// in_ready is low while parsing or while a result waits in the output
// register. loads arriving mid-run are dropped silently, pulls while loading
// give nothing. fill_flag_mask is written via cfg_we / cfg_wdata; the user
// must write it only while idle, the block itself does not enforce this.
module columnar_varint_span_decoder_core #(
	parameter int BUFFER_BYTES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cvsd_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output cvsd_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata
);
	import cvsd_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] BUF_FULL = PW'(BUFFER_BYTES);

	typedef enum logic [1:0] {PH_LOAD, PH_OVER, PH_RUN} phase_t;
	typedef enum logic [2:0] {S_IDLE, S_ADDR, S_DATA, S_STEP, S_PULL} state_t;
	typedef enum logic [3:0] {
		F_N, F_MIN, F_REG, F_CELL, F_CLEN,
		F_HQ, F_RID, F_CLR, F_FL, F_ST, F_DELTA, F_K
	} field_t;

	// byte buffer, undefined until written
	logic [7:0] mem [BUFFER_BYTES];
	logic [7:0] rdata_q;

	phase_t  phase_q;
	state_t  state_q;
	field_t  field_q;
	logic [PW-1:0] fill_q, ptr_q, lim_q;
	logic [PW-1:0] pos_q  [NCOL];
	logic [PW-1:0] clim_q [NCOL];
	logic [2:0]  col_q;
	logic        hdr_q, raw_q, vfirst_q, nbig_q;
	logic [1:0]  mincnt_q;
	logic [7:0]  byte_q, fl_q, fmask_q;
	logic [31:0] cell_q, cells_q, spans_q, regions_q, minh_q;
	logic [31:0] hq_q, rid_q;
	logic [15:0] clr_q;
	logic [11:0] tgt_q, done_q;
	logic        out_valid_q;
	out_t        out_q;

	logic [PW-1:0] cur_pos, cur_lim, remain;
	logic          accept, mem_we, ovf, cols_done, is_fill;
	logic [PW-1:0] fill_nx;
	vi_ctl_t       vctl;
	vi_res_t       vres;
	logic [31:0]   vsat;

	assign accept  = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the working pointer is the header cursor or one column cursor
	assign cur_pos = hdr_q ? ptr_q : pos_q[col_q];
	assign cur_lim = hdr_q ? lim_q : clim_q[col_q];
	assign remain  = lim_q - ptr_q;

	assign mem_we  = accept && !in_data.func && (phase_q != PH_RUN) && (fill_q < BUF_FULL);
	assign fill_nx = mem_we ? fill_q + PW'(1) : fill_q;
	assign ovf     = (phase_q == PH_OVER) || !(fill_q < BUF_FULL);

	assign vctl.feed  = (state_q == S_DATA) && !raw_q;
	assign vctl.first = vfirst_q;
	assign vsat       = vres.hi ? 32'hFFFF_FFFF : vres.val;
	assign is_fill    = (fl_q & fmask_q) != 8'd0;

	always_comb begin
		cols_done = 1'b1;
		for (int i = 0; i < NCOL; i++) begin
			if (pos_q[i] != clim_q[i]) cols_done = 1'b0;
		end
	end

	cvsd_varint u_varint (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (vctl),
		.din    (rdata_q),
		.res    (vres)
	);

	always_ff @(posedge clk) begin
		if (mem_we) mem[fill_q[AW-1:0]] <= in_data.payload_byte;
		rdata_q <= mem[cur_pos[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LOAD;
			state_q     <= S_IDLE;
			field_q     <= F_N;
			fill_q      <= '0;
			ptr_q       <= '0;
			lim_q       <= '0;
			for (int i = 0; i < NCOL; i++) begin
				pos_q[i]  <= '0;
				clim_q[i] <= '0;
			end
			col_q       <= '0;
			hdr_q       <= 1'b0;
			raw_q       <= 1'b0;
			vfirst_q    <= 1'b0;
			nbig_q      <= 1'b0;
			mincnt_q    <= '0;
			byte_q      <= '0;
			fl_q        <= '0;
			fmask_q     <= 8'd1;
			cell_q      <= '0;
			cells_q     <= '0;
			spans_q     <= '0;
			regions_q   <= '0;
			minh_q      <= '0;
			hq_q        <= '0;
			rid_q       <= '0;
			clr_q       <= '0;
			tgt_q       <= '0;
			done_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) fmask_q <= cfg_wdata;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept && !in_data.func && phase_q != PH_RUN) begin
						fill_q <= fill_nx;
						if (!(fill_q < BUF_FULL)) phase_q <= PH_OVER;
						if (in_data.byte_last) begin
							// clear run state before any header outcome
							for (int i = 0; i < NCOL; i++) begin
								pos_q[i]  <= '0;
								clim_q[i] <= '0;
							end
							cell_q    <= '0;
							cells_q   <= '0;
							spans_q   <= '0;
							tgt_q     <= '0;
							done_q    <= '0;
							regions_q <= '0;
							minh_q    <= '0;
							nbig_q    <= 1'b0;
							if (ovf) begin
								out_q        <= '0;
								out_q.status <= STAT_HDR_ERR;
								out_valid_q  <= 1'b1;
								phase_q      <= PH_LOAD;
								fill_q       <= '0;
							end else begin
								hdr_q    <= 1'b1;
								ptr_q    <= '0;
								lim_q    <= fill_nx;
								field_q  <= F_N;
								raw_q    <= 1'b0;
								vfirst_q <= 1'b1;
								state_q  <= S_ADDR;
							end
						end
					end else if (accept && in_data.func && phase_q == PH_RUN) begin
						hdr_q   <= 1'b0;
						state_q <= S_PULL;
					end
				end

				// bounds check, buffer read issued this cycle
				S_ADDR: begin
					if (cur_pos >= cur_lim) begin
						out_q       <= '0;
						out_valid_q <= 1'b1;
						phase_q     <= PH_LOAD;
						fill_q      <= '0;
						state_q     <= S_IDLE;
						if (hdr_q) begin
							out_q.status <= STAT_HDR_ERR;
							for (int i = 0; i < NCOL; i++) begin
								pos_q[i]  <= '0;
								clim_q[i] <= '0;
							end
							cells_q   <= '0;
							tgt_q     <= '0;
							regions_q <= '0;
							minh_q    <= '0;
						end else begin
							out_q.status <= STAT_END_ERR;
							out_q.last   <= 1'b1;
						end
					end else begin
						state_q <= S_DATA;
					end
				end

				S_DATA: begin
					if (hdr_q) ptr_q <= ptr_q + PW'(1);
					else pos_q[col_q] <= pos_q[col_q] + PW'(1);
					byte_q   <= rdata_q;
					vfirst_q <= 1'b0;
					if (raw_q || !rdata_q[7]) begin
						state_q <= S_STEP;
					end else if (vres.bad) begin
						// tenth byte still continues: malformed
						out_q       <= '0;
						out_valid_q <= 1'b1;
						phase_q     <= PH_LOAD;
						fill_q      <= '0;
						state_q     <= S_IDLE;
						if (hdr_q) begin
							out_q.status <= STAT_HDR_ERR;
							for (int i = 0; i < NCOL; i++) begin
								pos_q[i]  <= '0;
								clim_q[i] <= '0;
							end
							cells_q   <= '0;
							tgt_q     <= '0;
							regions_q <= '0;
							minh_q    <= '0;
						end else begin
							out_q.status <= STAT_END_ERR;
							out_q.last   <= 1'b1;
						end
					end else begin
						state_q <= S_ADDR;
					end
				end

				// one field finished: act on it and pick the next
				S_STEP: begin
					raw_q    <= 1'b0;
					vfirst_q <= 1'b1;
					state_q  <= S_ADDR;
					case (field_q)
						F_N: begin
							tgt_q  <= vres.val[11:0];
							nbig_q <= vres.hi || (vres.val > 32'(MAX_RECORDS));
							if (!vres.hi && vres.val == 32'd0) begin
								out_q       <= '0;
								out_valid_q <= 1'b1;
								state_q     <= S_IDLE;
								if (ptr_q == lim_q) begin
									out_q.status <= STAT_HDR_OK;
									phase_q      <= PH_RUN;
								end else begin
									out_q.status <= STAT_HDR_ERR;
									phase_q      <= PH_LOAD;
									fill_q       <= '0;
									tgt_q        <= '0;
								end
							end else if (remain < PW'(4)) begin
								out_q        <= '0;
								out_q.status <= STAT_HDR_ERR;
								out_valid_q  <= 1'b1;
								phase_q      <= PH_LOAD;
								fill_q       <= '0;
								tgt_q        <= '0;
								state_q      <= S_IDLE;
							end else begin
								mincnt_q <= '0;
								raw_q    <= 1'b1;
								field_q  <= F_MIN;
							end
						end
						F_MIN: begin
							// little-endian float bits
							minh_q   <= {byte_q, minh_q[31:8]};
							mincnt_q <= mincnt_q + 2'd1;
							if (mincnt_q == 2'd3) field_q <= F_REG;
							else raw_q <= 1'b1;
						end
						F_REG: begin
							regions_q <= vres.val;
							field_q   <= F_CELL;
						end
						F_CELL: begin
							cells_q <= vsat;
							col_q   <= '0;
							field_q <= F_CLEN;
						end
						F_CLEN: begin
							if (vres.hi || vres.val > 32'(remain) ||
							    (col_q == 3'(NCOL - 1) &&
							     (ptr_q + vres.val[PW-1:0] != lim_q || nbig_q))) begin
								out_q        <= '0;
								out_q.status <= STAT_HDR_ERR;
								out_valid_q  <= 1'b1;
								phase_q      <= PH_LOAD;
								fill_q       <= '0;
								state_q      <= S_IDLE;
								for (int i = 0; i < NCOL; i++) begin
									pos_q[i]  <= '0;
									clim_q[i] <= '0;
								end
								cells_q   <= '0;
								tgt_q     <= '0;
								regions_q <= '0;
								minh_q    <= '0;
							end else begin
								pos_q[col_q]  <= ptr_q;
								clim_q[col_q] <= ptr_q + vres.val[PW-1:0];
								ptr_q         <= ptr_q + vres.val[PW-1:0];
								if (col_q == 3'(NCOL - 1)) begin
									out_q                 <= '0;
									out_q.status          <= STAT_HDR_OK;
									out_q.min_height_bits <= minh_q;
									out_q.region_count    <= regions_q;
									out_q.record_count    <= tgt_q;
									out_valid_q           <= 1'b1;
									phase_q               <= PH_RUN;
									state_q               <= S_IDLE;
								end else begin
									col_q <= col_q + 3'd1;
								end
							end
						end
						F_HQ: begin
							hq_q    <= vsat;
							col_q   <= 3'd2;
							field_q <= F_RID;
						end
						F_RID: begin
							rid_q   <= vres.val;
							col_q   <= 3'd5;
							field_q <= F_CLR;
						end
						F_CLR: begin
							clr_q   <= vres.val[15:0];
							col_q   <= 3'd3;
							raw_q   <= 1'b1;
							field_q <= F_FL;
						end
						F_FL: begin
							fl_q    <= byte_q;
							col_q   <= 3'd4;
							raw_q   <= 1'b1;
							field_q <= F_ST;
						end
						F_ST: begin
							out_q              <= '0;
							out_q.status       <= STAT_SPAN;
							out_q.cell_index   <= cell_q;
							out_q.region_id    <= rid_q;
							out_q.clearance    <= clr_q;
							out_q.span_flags   <= fl_q;
							out_q.step_bits    <= byte_q;
							out_q.height_quant <= is_fill ? 32'd0 : hq_q;
							out_q.is_fill      <= is_fill;
							out_valid_q        <= 1'b1;
							spans_q            <= spans_q - 32'd1;
							done_q             <= done_q + 12'd1;
							state_q            <= S_IDLE;
						end
						F_DELTA: begin
							cell_q  <= cell_q + vres.val;
							field_q <= F_K;
						end
						F_K: begin
							cells_q <= cells_q - 32'd1;
							spans_q <= vsat;
							state_q <= S_PULL;
						end
						default: state_q <= S_IDLE;
					endcase
				end

				// pick the next record, cell descriptor or run end
				S_PULL: begin
					raw_q    <= 1'b0;
					vfirst_q <= 1'b1;
					if (spans_q != 32'd0) begin
						if (done_q >= tgt_q) begin
							out_q        <= '0;
							out_q.status <= STAT_END_ERR;
							out_q.last   <= 1'b1;
							out_valid_q  <= 1'b1;
							phase_q      <= PH_LOAD;
							fill_q       <= '0;
							state_q      <= S_IDLE;
						end else begin
							col_q   <= 3'd1;
							field_q <= F_HQ;
							state_q <= S_ADDR;
						end
					end else if (cells_q != 32'd0) begin
						col_q   <= 3'd0;
						field_q <= F_DELTA;
						state_q <= S_ADDR;
					end else begin
						out_q        <= '0;
						out_q.status <= (done_q == tgt_q && cols_done) ?
						                STAT_END_OK : STAT_END_ERR;
						out_q.last   <= 1'b1;
						out_valid_q  <= 1'b1;
						phase_q      <= PH_LOAD;
						fill_q       <= '0;
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
